>>> rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared constants, command and status codes, and word types.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int POOL_DEPTH   = 256;
  localparam int SLOT_W       = 8;
  localparam int CNT_W        = 9;
  localparam int OFS_W        = 15;
  localparam int UNIT_BYTES   = 64;
  localparam int HEADER_BYTES = 16;
  localparam int STRIDE       = UNIT_BYTES + HEADER_BYTES;

  localparam logic [OFS_W-1:0] STRIDE_B = OFS_W'(STRIDE);
  localparam logic [OFS_W-1:0] HEADER_B = OFS_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(POOL_DEPTH);

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EMPTY      = 2'd1;
  localparam logic [1:0] ST_NOT_IN_POOL = 2'd2;
  localparam logic [1:0] ST_NOT_ALLOC  = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [SLOT_W-1:0] slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
    logic [OFS_W-1:0]  byte_offset;
    logic [CNT_W-1:0]  allocated_count;
    logic [CNT_W-1:0]  free_count;
    logic [OFS_W-1:0]  total_bytes;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic empty;
  } dp_stat_t;

endpackage

>>> rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator controller
// Sequences one command through stack read and execute, and drives the strobe.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fbpa_pkg::dp_stat_t stat,
  output logic             busy,
  output logic             out_valid,
  output fbpa_pkg::ctrl_t  ctrl
);
  import fbpa_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // The empty flag is only informative here; the datapath settles the status.
  logic unused_empty;
  assign unused_empty = stat.empty;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign ctrl.load = start && (state_r == S_IDLE);
  assign ctrl.exec = (state_r == S_EXEC);

endmodule

>>> rtl/core/fbpa_dp.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator datapath
// Free stack memory, stack pointer, in-use bits, checks and result register.
// ----------------------------------------------------------------------------
module fbpa_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fbpa_pkg::ctrl_t              ctrl,
  input  fbpa_pkg::in_word_t           in_word,
  input  logic                         cfg_we,
  input  logic [fbpa_pkg::CNT_W-1:0]   cfg_wdata,
  output fbpa_pkg::dp_stat_t           stat,
  output fbpa_pkg::out_word_t          out_word
);
  import fbpa_pkg::*;

  logic [SLOT_W-1:0]     mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] stk_vld_r;
  logic [POOL_DEPTH-1:0] in_use_r;
  logic [POOL_DEPTH-1:0] in_use_nxt;
  logic [CNT_W-1:0]      unit_count_r;
  logic [CNT_W-1:0]      free_top_r;
  logic [CNT_W-1:0]      free_top_nxt;
  in_word_t              in_r;
  logic [SLOT_W-1:0]     rd_addr_r;
  logic [SLOT_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  out_word_t             out_r;
  out_word_t             out_nxt;
  logic [CNT_W-1:0]      top_dec;
  logic [SLOT_W-1:0]     rd_addr;
  logic [SLOT_W-1:0]     grant_s;
  logic                  push;
  logic [CNT_W-1:0]      cfg_count;

  assign top_dec = free_top_r - CNT_W'(1);
  assign rd_addr = top_dec[SLOT_W-1:0];
  assign grant_s = rd_vld_r ? rd_data_r : rd_addr_r;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_count = CNT_W'(1);
    end else if (cfg_wdata > DEPTH_C) begin
      cfg_count = DEPTH_C;
    end else begin
      cfg_count = cfg_wdata;
    end
  end

  always_comb begin
    free_top_nxt        = free_top_r;
    in_use_nxt          = in_use_r;
    push                = 1'b0;
    out_nxt.status       = ST_OK;
    out_nxt.granted_slot = '0;
    out_nxt.byte_offset  = '0;
    case (in_r.cmd)
      CMD_ALLOC: begin
        if (free_top_r == '0) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          free_top_nxt         = top_dec;
          in_use_nxt[grant_s]  = 1'b1;
          out_nxt.granted_slot = grant_s;
          out_nxt.byte_offset  = OFS_W'(grant_s) * STRIDE_B + HEADER_B;
        end
      end
      CMD_FREE: begin
        if ({1'b0, in_r.slot} >= unit_count_r) begin
          out_nxt.status = ST_NOT_IN_POOL;
        end else if (!in_use_r[in_r.slot]) begin
          out_nxt.status = ST_NOT_ALLOC;
        end else begin
          in_use_nxt[in_r.slot] = 1'b0;
          if (free_top_r < DEPTH_C) begin
            push         = 1'b1;
            free_top_nxt = free_top_r + CNT_W'(1);
          end
        end
      end
      default: begin
        out_nxt.status = ST_OK;
      end
    endcase
    out_nxt.allocated_count = unit_count_r - free_top_nxt;
    out_nxt.free_count      = free_top_nxt;
    out_nxt.total_bytes     = OFS_W'(unit_count_r) * STRIDE_B;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rd_data_r <= mem[rd_addr];
    end
    if (ctrl.exec && push) begin
      mem[free_top_r[SLOT_W-1:0]] <= in_r.slot;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      in_r      <= in_word;
      rd_addr_r <= rd_addr;
      rd_vld_r  <= stk_vld_r[rd_addr];
    end
    if (ctrl.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r <= DEPTH_C;
      free_top_r   <= DEPTH_C;
      in_use_r     <= '0;
      stk_vld_r    <= '0;
    end else if (cfg_we) begin
      unit_count_r <= cfg_count;
      free_top_r   <= cfg_count;
      in_use_r     <= '0;
      stk_vld_r    <= '0;
    end else if (ctrl.exec) begin
      free_top_r <= free_top_nxt;
      in_use_r   <= in_use_nxt;
      if (push) begin
        stk_vld_r[free_top_r[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  assign stat.empty = (free_top_r == '0);
  assign out_word   = out_r;

endmodule

>>> rtl/core/fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator core
// An accepted word is loaded with the stack read, then executed and registered.
// A new command is accepted only while idle; busy holds off the next one.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset and a write of unit_count free every slot at once, no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  fbpa_pkg::in_word_t           in_word,
  output logic                         out_valid,
  output fbpa_pkg::out_word_t          out_word,
  input  logic                         cfg_we,
  input  logic [fbpa_pkg::CNT_W-1:0]   cfg_wdata
);
  import fbpa_pkg::*;

  ctrl_t    ctrl;
  dp_stat_t stat;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  fbpa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/fbpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator checker
// Port-level properties of the core, attached by a bind statement.
// ----------------------------------------------------------------------------
module fbpa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input fbpa_pkg::in_word_t         in_word,
  input logic                       out_valid,
  input fbpa_pkg::out_word_t        out_word,
  input logic                       cfg_we,
  input logic [fbpa_pkg::CNT_W-1:0] cfg_wdata
);
  import fbpa_pkg::*;

  logic [CNT_W:0] slot_sum;
  assign slot_sum = {1'b0, out_word.allocated_count} + {1'b0, out_word.free_count};

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("core not busy after accepting a word");

  a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 out_valid)
    else $error("result word missing two cycles after acceptance");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_counts_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (OFS_W'(slot_sum) * STRIDE_B == out_word.total_bytes))
    else $error("slot counts disagree with total pool bytes");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != ST_OK) |->
      (out_word.granted_slot == '0) && (out_word.byte_offset == '0))
    else $error("failed command reports a slot");

  logic unused_ports;
  assign unused_ports = cfg_we ^ (^cfg_wdata) ^ (^in_word);

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word),
  .cfg_we    (cfg_we),
  .cfg_wdata (cfg_wdata)
);

>>> verif/tb_fixed_block_pool_allocator_core.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator core testbench
// Drives allocate, free, query and unknown words via the start/busy handshake.
// Every accepted word is run through a local model of the slot pool, and
// every strobed result is compared field by field with the oldest expected
// result. The slot count register is rewritten between phases while the
// core is idle. Both the extremes and random values are used.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  in_word_t            in_word   = '0;
  logic                out_valid;
  out_word_t           out_word;
  logic                cfg_we    = 1'b0;
  logic [CNT_W-1:0]    cfg_wdata = '0;

  fixed_block_pool_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Model of the pool.
  logic [SLOT_W-1:0] free_slots [POOL_DEPTH];
  int unsigned       free_depth;
  bit                slot_taken [POOL_DEPTH];
  int unsigned       pool_units;

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int        error_count = 0;
  int        gap_pct     = 11;

  function automatic void pool_load(logic [CNT_W-1:0] value);
    int unsigned n;
    n = value;
    if (n < 1) n = 1;
    if (n > POOL_DEPTH) n = POOL_DEPTH;
    pool_units = n;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      free_slots[i] = SLOT_W'(i);
      slot_taken[i] = 1'b0;
    end
    free_depth = n;
  endfunction

  function automatic out_word_t pool_command(in_word_t w);
    out_word_t r;
    int unsigned s;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          free_depth--;
          s = free_slots[free_depth];
          slot_taken[s] = 1'b1;
          r.granted_slot = SLOT_W'(s);
          r.byte_offset = OFS_W'(s * STRIDE + HEADER_BYTES);
        end
      end
      CMD_FREE: begin
        if (w.slot >= pool_units) begin
          r.status = ST_NOT_IN_POOL;
        end else if (!slot_taken[w.slot]) begin
          r.status = ST_NOT_ALLOC;
        end else begin
          slot_taken[w.slot] = 1'b0;
          if (free_depth < POOL_DEPTH) begin
            free_slots[free_depth] = w.slot;
            free_depth++;
          end
        end
      end
      default: begin
      end
    endcase
    r.allocated_count = CNT_W'(pool_units - free_depth);
    r.free_count = CNT_W'(free_depth);
    r.total_bytes = OFS_W'(pool_units * STRIDE);
    return r;
  endfunction

  // Command driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(pool_command(in_word));
      end
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, name, expv, actv);
      error_count++;
    end
  endtask

  // Result monitor.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, out_word);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("status", want.status, out_word.status);
        check_field("granted_slot", want.granted_slot, out_word.granted_slot);
        check_field("byte_offset", want.byte_offset, out_word.byte_offset);
        check_field("allocated_count", want.allocated_count, out_word.allocated_count);
        check_field("free_count", want.free_count, out_word.free_count);
        check_field("total_bytes", want.total_bytes, out_word.total_bytes);
      end
    end
  end

  task automatic push(logic [1:0] cmd, logic [SLOT_W-1:0] slot);
    in_word_t w;
    w.cmd = cmd;
    w.slot = slot;
    pending_words.push_back(w);
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || start || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_units(logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_load(value);
    @(posedge clk);
  endtask

  task automatic random_phase(logic [CNT_W-1:0] units, int count, int alloc_pct);
    int r;
    write_units(units);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < alloc_pct) begin
        push(CMD_ALLOC, SLOT_W'($urandom_range(255)));
      end else if (r < 90) begin
        push(CMD_FREE, SLOT_W'($urandom_range(pool_units - 1)));
      end else if (r < 95) begin
        push(CMD_FREE, SLOT_W'($urandom_range(255)));
      end else if (r < 98) begin
        push(CMD_QUERY, SLOT_W'($urandom_range(255)));
      end else begin
        push(CMD_UNKNOWN, SLOT_W'($urandom_range(255)));
      end
    end
    settle();
  endtask

  initial begin
    pool_load(CNT_W'(POOL_DEPTH));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: the highest slot is handed out first.
    push(CMD_ALLOC, 8'h00);
    push(CMD_ALLOC, 8'hFF);
    push(CMD_FREE, 8'hFF);
    push(CMD_FREE, 8'hFF);
    push(CMD_FREE, 8'h00);
    push(CMD_QUERY, 8'hFF);
    push(CMD_UNKNOWN, 8'h55);
    push(CMD_FREE, 8'hFE);
    settle();

    // A single slot: the pool runs empty and high slots lie outside it.
    write_units(9'd1);
    push(CMD_ALLOC, 8'hAA);
    push(CMD_ALLOC, 8'h00);
    push(CMD_FREE, 8'h01);
    push(CMD_FREE, 8'hFF);
    push(CMD_FREE, 8'h00);
    push(CMD_FREE, 8'h00);
    push(CMD_QUERY, 8'h00);
    settle();

    // A zero count is taken as one, an oversized count as the full pool.
    write_units(9'd0);
    push(CMD_QUERY, 8'h00);
    push(CMD_ALLOC, 8'h00);
    push(CMD_ALLOC, 8'h00);
    settle();
    write_units(9'h1FF);
    push(CMD_QUERY, 8'hFF);
    push(CMD_ALLOC, 8'h00);
    push(CMD_FREE, 8'hFF);
    settle();

    random_phase(9'd256, 400, 70);
    random_phase(9'd3, 120, 50);
    gap_pct = 0;
    random_phase(9'd256, 300, 40);
    gap_pct = 11;
    random_phase(9'd17, 150, 55);
    random_phase(9'd2, 100, 50);
    random_phase(CNT_W'($urandom_range(300)), 150, 60);
    random_phase(CNT_W'($urandom_range(1, 64)), 150, 50);
    random_phase(9'd257, 100, 30);

    if (error_count == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
